/* hw/rtl/atkdither_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// atkdither_pkg
// Shared widths, register indexes and the error saturation helper for the
// atkinson error diffusion dither unit.
// ---------------------------------------------------------------------------
package atkdither_pkg;

    localparam int PIXEL_W    = 8;
    localparam int ERR_W      = 16;
    localparam int SUM_W      = 18;   // wide sums before saturation
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int IWIDTH_W   = 11;
    localparam int IHEIGHT_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [IWIDTH_W-1:0]  IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [IHEIGHT_W-1:0] IMAGE_HEIGHT_RST = 16'd480;

    typedef logic signed [ERR_W-1:0] err_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    localparam sum_t ERR_MAX = sum_t'(32767);
    localparam sum_t ERR_MIN = -sum_t'(32768);

    function automatic err_t sat_err(input sum_t v);
        err_t r;
        if (v > ERR_MAX) begin
            r = err_t'(32767);
        end else if (v < ERR_MIN) begin
            r = -err_t'(32767) - err_t'(1);
        end else begin
            r = v[ERR_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/atkinson_error_diffusion_dither_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// atkinson_error_diffusion_dither_unit
// Atkinson error diffusion of an 8-bit gray pixel stream to one dot a pixel.
// ---------------------------------------------------------------------------
// Usage: pixels enter in raster order on the s_ channel (valid/ready), one
// word per pixel, and each gives one word on the m_ channel: the dot (1 is
// white) and a frame_end flag on the last pixel of the frame.
// image_width and image_height are written on the cfg port while the block
// is idle; both are taken up at the first pixel of each frame.
// Each pixel passes the stage 1 register, then the output register. Throughput:
// one pixel per clock unless m_ready stalls it, set by the single pass from
// the input stage (line store reads registered there) to the output register.
// The two line stores each have one write and one read a cycle; the last
// column of a row lives in registers so that one write a pixel suffices.
// Reset: position returns to the top left, registers take their defaults.
// No clearing pass is needed: the first row of every frame treats the line
// stores as zero and rewrites every column it uses.
// Stalls: while m_ready is low the output register holds its word; one more
// pixel can wait in the input stage before s_ready drops.
// ---------------------------------------------------------------------------
module atkinson_error_diffusion_dither_unit
    import atkdither_pkg::*;
#(
    parameter int MAX_WIDTH     = 1024,
    parameter int FRACTION_BITS = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIXEL_W-1:0]    s_gray_pixel,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_dot,
    output logic                  m_frame_end,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int FW  = $clog2(MAX_WIDTH + 1);
    localparam int CW  = (FW > IWIDTH_W) ? FW : IWIDTH_W;
    localparam sum_t FULL_SCALE = sum_t'(255 << FRACTION_BITS);
    localparam sum_t HALF_SCALE = sum_t'(255 << (FRACTION_BITS - 1));

    // configuration
    logic [IWIDTH_W-1:0]  image_width_reg;
    logic [IHEIGHT_W-1:0] image_height_reg;

    // input side position
    logic [AW-1:0]        in_col_reg;
    logic [IHEIGHT_W-1:0] in_row_reg;
    logic [FW-1:0]        fw_reg;
    logic [IHEIGHT_W-1:0] fh_reg;

    logic                 accept;
    logic                 commit;
    logic                 frame_start;
    logic [CW-1:0]        iw_ext;
    logic [FW-1:0]        fw_clamped;
    logic [FW-1:0]        fw_cur;
    logic [IHEIGHT_W-1:0] fh_cur;
    logic                 in_last_col;
    logic                 in_last_row;
    logic                 in_has2;
    logic [AW-1:0]        in_col_next;
    logic [IHEIGHT_W-1:0] in_row_next;

    // stage 1
    logic                 s1_valid_reg;
    logic [PIXEL_W-1:0]   s1_pixel_reg;
    logic [AW-1:0]        s1_col_reg;
    logic                 s1_col0_reg;
    logic                 s1_last_col_reg;
    logic                 s1_last_row_reg;
    logic                 s1_first_row_reg;
    logic                 s1_has1_reg;
    logic                 s1_has2_reg;

    // line stores
    err_t                 next_mem [MAX_WIDTH];
    err_t                 second_mem [MAX_WIDTH];
    err_t                 next_rd_reg;
    err_t                 second_rd_reg;
    logic                 fwd_hit_reg;
    err_t                 fwd_data_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;

    // diffusion state
    err_t                 ahead_one_reg;
    err_t                 ahead_two_reg;
    err_t                 prev_one_reg;
    err_t                 prev_two_reg;
    err_t                 tail_next_reg;
    err_t                 tail_second_reg;

    err_t                 a1;
    err_t                 a2;
    err_t                 p1;
    err_t                 p2;
    err_t                 nr_val;
    err_t                 sr_val;
    err_t                 st_val;
    sum_t                 pix_fx;
    sum_t                 v;
    sum_t                 err;
    sum_t                 err_sh;
    err_t                 e;
    logic                 white;
    err_t                 ahead_one_next;
    err_t                 ahead_two_next;
    err_t                 mid_next;
    err_t                 tail_next_next;

    // output register
    logic                 m_valid_reg;
    logic                 dot_reg;
    logic                 frame_end_reg;

    assign commit  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || commit;
    assign accept  = s_valid && s_ready;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    image_width_reg <= cfg_wdata[IWIDTH_W-1:0];
                end
                REG_IMAGE_HEIGHT: begin
                    image_height_reg <= cfg_wdata[IHEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- input side position ----------------
    assign frame_start = (in_col_reg == '0) && (in_row_reg == '0);
    assign iw_ext      = CW'(image_width_reg);

    always_comb begin
        if (iw_ext == '0) begin
            fw_clamped = FW'(1);
        end else if (iw_ext > CW'(MAX_WIDTH)) begin
            fw_clamped = FW'(MAX_WIDTH);
        end else begin
            fw_clamped = iw_ext[FW-1:0];
        end
    end

    assign fw_cur = frame_start ? fw_clamped : fw_reg;
    assign fh_cur = frame_start ? ((image_height_reg == '0) ? IHEIGHT_W'(1) : image_height_reg)
                                : fh_reg;

    assign in_last_col = (FW'(in_col_reg) == (fw_cur - FW'(1)));
    assign in_last_row = (in_row_reg >= (fh_cur - IHEIGHT_W'(1)));
    assign in_has2     = ((FW+1)'(in_col_reg) + (FW+1)'(2)) < (FW+1)'(fw_cur);

    always_comb begin
        if (in_last_col) begin
            in_col_next = '0;
            in_row_next = in_last_row ? '0 : in_row_reg + IHEIGHT_W'(1);
        end else begin
            in_col_next = in_col_reg + AW'(1);
            in_row_next = in_row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            fw_reg     <= FW'(1);
            fh_reg     <= IHEIGHT_W'(1);
        end else if (accept) begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            fw_reg     <= fw_cur;
            fh_reg     <= fh_cur;
        end
    end

    // ---------------- stage 1 register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
            // write of the same edge is not seen by the store read
            fwd_hit_reg  <= mem_we && (mem_wa == in_col_reg);
        end else if (commit) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pixel_reg     <= s_gray_pixel;
            s1_col_reg       <= in_col_reg;
            s1_col0_reg      <= (in_col_reg == '0);
            s1_last_col_reg  <= in_last_col;
            s1_last_row_reg  <= in_last_row;
            s1_first_row_reg <= (in_row_reg == '0);
            s1_has1_reg      <= !in_last_col;
            s1_has2_reg      <= in_has2;
            fwd_data_reg     <= mid_next;
        end
    end

    // ---------------- line stores ----------------
    // the last column is kept in tail registers, so only column x-1 is written here
    assign mem_we = commit && !s1_col0_reg;
    assign mem_wa = s1_col_reg - AW'(1);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            next_mem[mem_wa] <= mid_next;
        end
        if (accept) begin
            next_rd_reg <= next_mem[in_col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            second_mem[mem_wa] <= p1;
        end
        if (accept) begin
            second_rd_reg <= second_mem[in_col_reg - AW'(1)];
        end
    end

    // ---------------- diffusion arithmetic ----------------
    assign a1 = s1_col0_reg ? '0 : ahead_one_reg;
    assign a2 = s1_col0_reg ? '0 : ahead_two_reg;
    assign p1 = s1_col0_reg ? '0 : prev_one_reg;
    assign p2 = s1_col0_reg ? '0 : prev_two_reg;

    // first row of a frame sees cleared stores
    always_comb begin
        if (s1_first_row_reg) begin
            nr_val = '0;
        end else if (s1_last_col_reg) begin
            nr_val = tail_next_reg;
        end else if (fwd_hit_reg) begin
            nr_val = fwd_data_reg;
        end else begin
            nr_val = next_rd_reg;
        end
    end

    assign sr_val = s1_first_row_reg ? '0 : second_rd_reg;
    assign st_val = s1_first_row_reg ? '0 : tail_second_reg;

    assign pix_fx = sum_t'(SUM_W'(s1_pixel_reg) << FRACTION_BITS);
    assign v      = pix_fx + sum_t'(nr_val) + sum_t'(a1);
    assign white  = (v >= HALF_SCALE);
    assign err    = white ? (v - FULL_SCALE) : v;
    assign err_sh = err >>> 3;
    assign e      = err_sh[ERR_W-1:0];

    assign ahead_one_next = sat_err(sum_t'(a2) + (s1_has1_reg ? sum_t'(e) : '0));
    assign ahead_two_next = s1_has2_reg ? e : '0;
    assign mid_next       = sat_err(sum_t'(sr_val) + sum_t'(p2) + sum_t'(p1) + sum_t'(e));
    assign tail_next_next = sat_err(sum_t'(st_val) + sum_t'(p1) + sum_t'(e));

    always_ff @(posedge aclk) begin
        if (commit) begin
            ahead_one_reg <= ahead_one_next;
            ahead_two_reg <= ahead_two_next;
            prev_one_reg  <= e;
            prev_two_reg  <= p1;
            if (s1_last_col_reg) begin
                tail_next_reg   <= tail_next_next;
                tail_second_reg <= e;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            dot_reg       <= white;
            frame_end_reg <= s1_last_col_reg && s1_last_row_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_dot       = dot_reg;
    assign m_frame_end = frame_end_reg;

endmodule
